// File: rtl/sao_pkg.sv
// ---------------------------------------------------------------------------
// sao_pkg
// Shared types and codes of the sample adaptive offset filter unit.
// ---------------------------------------------------------------------------
package sao_pkg;

	localparam int BAND_BITS   = 5;
	localparam int SMP_W       = 8;
	localparam int OFS_W       = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;
	localparam int BSIZE_W     = 7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAO_TYPE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_CLASS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_POSITION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FIRST  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SECOND = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_THIRD  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FOURTH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 3'd7;

	typedef enum logic [1:0] {
		SAO_OFF  = 2'd0,
		SAO_BAND = 2'd1,
		SAO_EDGE = 2'd2,
		SAO_RSVD = 2'd3
	} sao_type_t;

	typedef enum logic [1:0] {
		EDGE_HOR = 2'd0,
		EDGE_VER = 2'd1,
		EDGE_DR  = 2'd2,
		EDGE_DL  = 2'd3
	} edge_class_t;

	typedef struct packed {
		logic             keep;
		logic             usable;
		logic [SMP_W-1:0] smp;
	} pix_t;

	// one line store entry: the two rows above the incoming one
	typedef struct packed {
		pix_t top;
		pix_t mid;
	} line_pair_t;

endpackage

// File: rtl/sao_ram.sv
// ---------------------------------------------------------------------------
// sao_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module sao_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 66
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/sample_adaptive_offset_filter_unit.sv
// ---------------------------------------------------------------------------
// sample_adaptive_offset_filter_unit
// Streams a bordered block in raster order, keeps two lines in a RAM and a
// 3x3 window in registers, and applies band or edge offset to inner samples.
//
//   channel   signals                                   direction
//   in        in_valid/in_ready: sample, usable,        into block
//             keep_unchanged
//   out       out_valid/out_ready: filtered,            out of block
//             last_of_block
//   config    wr_en, wr_index, wr_data                  into block
//
// One item per cycle sustained while the output is not stalled. The line RAM is read
// when an item is taken, the window is filtered and the RAM written back when
// the item leaves stage 1, and the result sits in the output register.
// Reset clears the configuration and counters; line RAM and window start
// undefined and are filled by the border rows of the first block.
// A stalled output holds the item in the filter stage; input is still taken
// while the output register can drain in the same cycle.
// ---------------------------------------------------------------------------
module sample_adaptive_offset_filter_unit #(
	parameter int MAX_BLOCK = 64,
	parameter int BIT_DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [sao_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [sao_pkg::CFG_DATA_W-1:0]    wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sao_pkg::SMP_W-1:0]         sample,
	input  logic                              usable,
	input  logic                              keep_unchanged,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sao_pkg::SMP_W-1:0]         filtered,
	output logic                              last_of_block
);

	localparam int ROW_LEN    = MAX_BLOCK + 2;
	localparam int CW         = $clog2(ROW_LEN);
	localparam int BAND_SHIFT = BIT_DEPTH - sao_pkg::BAND_BITS;
	localparam int SUM_W      = sao_pkg::SMP_W + 2;
	localparam logic [SUM_W-1:0] PIX_MAX = SUM_W'((1 << BIT_DEPTH) - 1);
	localparam logic [sao_pkg::BSIZE_W-1:0] MAX_N = sao_pkg::BSIZE_W'(MAX_BLOCK);

	// configuration
	sao_pkg::sao_type_t          sao_type_q;
	sao_pkg::edge_class_t        edge_class_q;
	logic [sao_pkg::BAND_BITS-1:0] band_position_q;
	logic [sao_pkg::OFS_W-1:0]   offset_q [4];
	logic [sao_pkg::BSIZE_W-1:0] block_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sao_type_q      <= sao_pkg::SAO_OFF;
			edge_class_q    <= sao_pkg::EDGE_HOR;
			band_position_q <= '0;
			offset_q        <= '{default: '0};
			block_size_q    <= sao_pkg::BSIZE_W'(64);
		end else if (wr_en) begin
			unique case (wr_index)
				sao_pkg::REG_SAO_TYPE:      sao_type_q <= sao_pkg::sao_type_t'(wr_data[1:0]);
				sao_pkg::REG_EDGE_CLASS:    edge_class_q <= sao_pkg::edge_class_t'(wr_data[1:0]);
				sao_pkg::REG_BAND_POSITION: band_position_q <= wr_data[sao_pkg::BAND_BITS-1:0];
				sao_pkg::REG_OFFSET_FIRST:  offset_q[0] <= wr_data;
				sao_pkg::REG_OFFSET_SECOND: offset_q[1] <= wr_data;
				sao_pkg::REG_OFFSET_THIRD:  offset_q[2] <= wr_data;
				sao_pkg::REG_OFFSET_FOURTH: offset_q[3] <= wr_data;
				sao_pkg::REG_BLOCK_SIZE:    block_size_q <= wr_data[sao_pkg::BSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// window position counters
	logic [CW-1:0] col_q, row_q, last_pos;
	logic [sao_pkg::BSIZE_W-1:0] n_eff;

	always_comb begin
		priority if (block_size_q == '0) begin
			n_eff = sao_pkg::BSIZE_W'(1);
		end else if (block_size_q > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = block_size_q;
		end
		last_pos = CW'(n_eff) + CW'(1);
	end

	logic in_fire, s1_adv;
	logic s1_valid_q;

	assign in_ready = !s1_valid_q || s1_adv;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (col_q >= last_pos) begin
				col_q <= '0;
				row_q <= (row_q >= last_pos) ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: item waits for its line RAM data
	sao_pkg::pix_t cur_s1;
	logic [CW-1:0] col_s1;
	logic          emit_s1, last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_s1  <= '{keep: keep_unchanged, usable: usable, smp: sample};
			col_s1  <= col_q;
			emit_s1 <= (row_q >= CW'(2)) && (col_q >= CW'(2));
			last_s1 <= (row_q >= last_pos) && (col_q >= last_pos);
		end
	end

	// line RAM: column address, holds the two rows above
	sao_pkg::line_pair_t rd_pair, wr_pair;

	assign wr_pair = '{top: rd_pair.mid, mid: cur_s1};

	sao_ram #(
		.WIDTH($bits(sao_pkg::line_pair_t)),
		.DEPTH(ROW_LEN)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(col_s1),
		.wdata(wr_pair),
		.re   (in_fire),
		.raddr(col_q),
		.rdata(rd_pair)
	);

	// window columns left of the RAM column: [row][0 = oldest]
	sao_pkg::pix_t nb_q [3][2];

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			nb_q[0][0] <= nb_q[0][1];
			nb_q[0][1] <= rd_pair.top;
			nb_q[1][0] <= nb_q[1][1];
			nb_q[1][1] <= rd_pair.mid;
			nb_q[2][0] <= nb_q[2][1];
			nb_q[2][1] <= cur_s1;
		end
	end

	// filter
	sao_pkg::pix_t ctr, nbr_a, nbr_b;
	logic [sao_pkg::SMP_W-1:0] s;
	logic [2:0] esum, ecat;
	logic [sao_pkg::BAND_BITS-1:0] band, kband;
	logic [1:0] ofs_idx;
	logic apply;
	logic signed [SUM_W-1:0] sum;
	logic [sao_pkg::SMP_W-1:0] result;

	always_comb begin
		ctr = nb_q[1][1];
		s   = ctr.smp;

		unique case (edge_class_q)
			sao_pkg::EDGE_HOR: begin
				nbr_a = nb_q[1][0];
				nbr_b = rd_pair.mid;
			end
			sao_pkg::EDGE_VER: begin
				nbr_a = nb_q[0][1];
				nbr_b = nb_q[2][1];
			end
			sao_pkg::EDGE_DR: begin
				nbr_a = nb_q[0][0];
				nbr_b = cur_s1;
			end
			default: begin
				nbr_a = rd_pair.top;
				nbr_b = nb_q[2][0];
			end
		endcase

		esum = 3'd2 + 3'(s > nbr_a.smp) + 3'(s > nbr_b.smp)
		       - 3'(s < nbr_a.smp) - 3'(s < nbr_b.smp);
		unique case (esum)
			3'd0:    ecat = 3'd1;
			3'd1:    ecat = 3'd2;
			3'd3:    ecat = 3'd3;
			3'd4:    ecat = 3'd4;
			default: ecat = 3'd0;
		endcase

		band  = sao_pkg::BAND_BITS'(s >> BAND_SHIFT);
		kband = band - band_position_q;

		apply   = 1'b0;
		ofs_idx = '0;
		if (!ctr.keep && ctr.usable) begin
			if (sao_type_q == sao_pkg::SAO_BAND) begin
				apply   = (kband < sao_pkg::BAND_BITS'(4));
				ofs_idx = kband[1:0];
			end else if (sao_type_q == sao_pkg::SAO_EDGE) begin
				apply   = nbr_a.usable && nbr_b.usable && (ecat != 3'd0);
				ofs_idx = 2'(ecat - 3'd1);
			end
		end

		sum = $signed({2'b00, s}) + SUM_W'($signed(offset_q[ofs_idx]));

		priority if (!apply) begin
			result = s;
		end else if (sum < 0) begin
			result = '0;
		end else if (sum > $signed(PIX_MAX)) begin
			result = PIX_MAX[sao_pkg::SMP_W-1:0];
		end else begin
			result = sum[sao_pkg::SMP_W-1:0];
		end
	end

	// output register
	logic out_valid_q;
	logic [sao_pkg::SMP_W-1:0] filtered_q;
	logic last_q;

	assign s1_adv = s1_valid_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			filtered_q <= result;
			last_q     <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign filtered      = filtered_q;
	assign last_of_block = last_q;

endmodule

// File: test/tb_sample_adaptive_offset_filter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sample_adaptive_offset_filter_unit
// Streams bordered blocks through the offset filter under several idle and
// stall patterns. A cycle-free predictor tracks the line stores, the 3x3
// window and the counters, and every output item is checked in order.
// ---------------------------------------------------------------------------
module tb_sample_adaptive_offset_filter_unit;
	import sao_pkg::*;

	localparam int MAX_BLOCK   = 64;
	localparam int ROW_LEN     = MAX_BLOCK + 2;
	localparam int MAX_PIX     = (1 << SMP_W) - 1;
	localparam int STALL_LIMIT = 4000;
	localparam int RAND_ITEMS  = 700;

	typedef struct packed {
		logic [SMP_W-1:0] filtered;
		logic             last;
	} sao_result_t;

	class filtered_sample_board;
		sao_type_t          mode;
		edge_class_t        edge_dir;
		logic [4:0]         band_pos;
		logic signed [7:0]  ofs [4];
		logic [6:0]         bsize;
		pix_t               lines [2*ROW_LEN];
		pix_t               win [6];
		int                 col;
		int                 row;
		sao_result_t        expected_filtered [$];
		int                 errors;

		function new();
			mode = SAO_OFF;
			edge_dir = EDGE_HOR;
			band_pos = '0;
			foreach (ofs[i]) ofs[i] = '0;
			bsize = 7'd64;
			foreach (lines[i]) lines[i] = '0;
			foreach (win[i]) win[i] = '0;
			col = 0;
			row = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SAO_TYPE:      mode = sao_type_t'(data[1:0]);
				REG_EDGE_CLASS:    edge_dir = edge_class_t'(data[1:0]);
				REG_BAND_POSITION: band_pos = data[4:0];
				REG_OFFSET_FIRST:  ofs[0] = data;
				REG_OFFSET_SECOND: ofs[1] = data;
				REG_OFFSET_THIRD:  ofs[2] = data;
				REG_OFFSET_FOURTH: ofs[3] = data;
				REG_BLOCK_SIZE:    bsize = data[6:0];
				default: ;
			endcase
		endfunction

		function logic [SMP_W-1:0] clip_pix(int v);
			if (v < 0) return '0;
			if (v > MAX_PIX) return MAX_PIX[SMP_W-1:0];
			return v[SMP_W-1:0];
		endfunction

		function int sign_of(int d);
			return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
		endfunction

		function logic [SMP_W-1:0] offset_center(pix_t ctr, pix_t nb_a, pix_t nb_b);
			int         s;
			int         cat;
			logic [4:0] k;
			s = int'(ctr.smp);
			if (mode == SAO_OFF || mode == SAO_RSVD) return ctr.smp;
			if (ctr.keep || !ctr.usable) return ctr.smp;
			if (mode == SAO_BAND) begin
				k = ctr.smp[SMP_W-1 -: BAND_BITS] - band_pos;
				if (k >= 5'd4) return ctr.smp;
				return clip_pix(s + int'(ofs[k[1:0]]));
			end
			if (!nb_a.usable || !nb_b.usable) return ctr.smp;
			cat = 2 + sign_of(s - int'(nb_a.smp)) + sign_of(s - int'(nb_b.smp));
			if (cat == 2) return ctr.smp;
			if (cat < 2) cat = cat + 1;
			return clip_pix(s + int'(ofs[cat-1]));
		endfunction

		function void take_window_sample(logic [SMP_W-1:0] smp, logic use_bit, logic keep_bit);
			int          n;
			int          last;
			pix_t        cur;
			pix_t        top;
			pix_t        mid;
			pix_t        nb_a;
			pix_t        nb_b;
			sao_result_t res;
			n = int'(bsize);
			if (n < 1) n = 1;
			if (n > MAX_BLOCK) n = MAX_BLOCK;
			last = n + 1;
			cur = {keep_bit, use_bit, smp};
			top = '0;
			mid = '0;
			if (col < ROW_LEN) begin
				top = lines[col];
				mid = lines[ROW_LEN+col];
			end
			// window: win[0..1] top row, win[2..3] middle, win[4..5] bottom
			case (edge_dir)
				EDGE_HOR: begin nb_a = win[2]; nb_b = mid;    end
				EDGE_VER: begin nb_a = win[1]; nb_b = win[5]; end
				EDGE_DR:  begin nb_a = win[0]; nb_b = cur;    end
				default:  begin nb_a = top;    nb_b = win[4]; end
			endcase
			if (row >= 2 && col >= 2) begin
				res.filtered = offset_center(win[3], nb_a, nb_b);
				res.last = (row >= last && col >= last);
				expected_filtered.push_back(res);
			end
			win[0] = win[1]; win[1] = top;
			win[2] = win[3]; win[3] = mid;
			win[4] = win[5]; win[5] = cur;
			if (col < ROW_LEN) begin
				lines[col] = mid;
				lines[ROW_LEN+col] = cur;
			end
			if (col >= last) begin
				col = 0;
				row = (row >= last) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function bit at_block_start();
			return col == 0 && row == 0;
		endfunction

		function int pending();
			return expected_filtered.size();
		endfunction

		function void check_filtered(logic [SMP_W-1:0] got_pix, logic got_last);
			sao_result_t want;
			if (expected_filtered.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t unexpected item: filtered %0d last %0b",
						$realtime, got_pix, got_last);
				return;
			end
			want = expected_filtered.pop_front();
			if (want.filtered !== got_pix || want.last !== got_last) begin
				errors++;
				if (errors <= 10)
					$display("%0t mismatch: filtered exp %0d got %0d, last exp %0b got %0b",
						$realtime, want.filtered, got_pix, want.last, got_last);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [SMP_W-1:0]      sample;
	logic                  usable;
	logic                  keep_unchanged;
	logic                  out_valid;
	logic                  out_ready;
	logic [SMP_W-1:0]      filtered;
	logic                  last_of_block;

	filtered_sample_board board;
	int                   in_idle_pct;
	int                   out_stall_pct;
	int                   items_sent;
	int                   stall_cycles = 0;
	logic [SMP_W-1:0]     flat_base;

	sample_adaptive_offset_filter_unit #(
		.MAX_BLOCK(MAX_BLOCK),
		.BIT_DEPTH(SMP_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.usable(usable),
		.keep_unchanged(keep_unchanged),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered(filtered),
		.last_of_block(last_of_block)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_filtered(filtered, last_of_block);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("FAIL sample_adaptive_offset_filter_unit");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		board.set_reg(idx, data);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic send_item(input logic [SMP_W-1:0] smp, input logic use_bit,
		input logic keep_bit);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= smp;
		usable <= use_bit;
		keep_unchanged <= keep_bit;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		board.take_window_sample(smp, use_bit, keep_bit);
		items_sent++;
	endtask

	task automatic send_random_item(input int style);
		logic [SMP_W-1:0] s;
		logic             u;
		logic             k;
		case (style)
			0: s = SMP_W'($urandom_range(0, MAX_PIX));
			1: s = flat_base + SMP_W'($urandom_range(0, 2));
			default: s = $urandom_range(0, 1) ? MAX_PIX[SMP_W-1:0] : '0;
		endcase
		u = ($urandom_range(0, 7) != 0);
		k = ($urandom_range(0, 7) == 0);
		send_item(s, u, k);
	endtask

	task automatic send_block(input int style);
		do
			send_random_item(style);
		while (!board.at_block_start());
	endtask

	// 3x3 window, block size 1, all usable
	task automatic send_pattern(input logic [0:8][SMP_W-1:0] p);
		for (int i = 0; i < 9; i++)
			send_item(p[i], 1'b1, 1'b0);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic randomize_config();
		logic [31:0]     junk;
		int              roll;
		sao_type_t       mode_val;
		logic [7:0]      ofs_val;
		junk = $urandom;
		roll = $urandom_range(0, 9);
		if (roll == 0) mode_val = SAO_OFF;
		else if (roll <= 4) mode_val = SAO_BAND;
		else if (roll <= 8) mode_val = SAO_EDGE;
		else mode_val = SAO_RSVD;
		write_reg(REG_SAO_TYPE, {junk[5:0], mode_val});
		write_reg(REG_EDGE_CLASS, {junk[11:6], 2'($urandom_range(0, 3))});
		write_reg(REG_BAND_POSITION, {junk[14:12], 5'($urandom_range(0, 31))});
		for (int i = 0; i < 4; i++) begin
			ofs_val = 8'($urandom);
			if ($urandom_range(0, 3) == 0) ofs_val = $urandom_range(0, 1) ? 8'h7F : 8'h80;
			case (i)
				0: write_reg(REG_OFFSET_FIRST, ofs_val);
				1: write_reg(REG_OFFSET_SECOND, ofs_val);
				2: write_reg(REG_OFFSET_THIRD, ofs_val);
				default: write_reg(REG_OFFSET_FOURTH, ofs_val);
			endcase
		end
		write_reg(REG_BLOCK_SIZE, {junk[15], 7'($urandom_range(1, 8))});
	endtask

	task automatic set_idling(input int sel);
		case (sel % 4)
			0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
			1: begin in_idle_pct = 75; out_stall_pct = 0;  end
			2: begin in_idle_pct = 0;  out_stall_pct = 75; end
			default: begin in_idle_pct = 35; out_stall_pct = 35; end
		endcase
	endtask

	initial begin
		int rand_start;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		sample = '0;
		usable = 1'b0;
		keep_unchanged = 1'b0;
		out_ready = 1'b0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		items_sent = 0;
		flat_base = '0;
		board = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// local minimum clipped high, horizontal
		write_reg(REG_SAO_TYPE, CFG_DATA_W'(SAO_EDGE));
		write_reg(REG_EDGE_CLASS, CFG_DATA_W'(EDGE_HOR));
		write_reg(REG_OFFSET_FIRST, 8'h7F);
		write_reg(REG_OFFSET_FOURTH, 8'h80);
		write_reg(REG_BLOCK_SIZE, 8'd1);
		send_pattern({8'd9, 8'd9, 8'd9, 8'd255, 8'd200, 8'd255, 8'd9, 8'd9, 8'd9});
		drain();
		// local maximum clipped low, down-left; size 0 acts as 1
		write_reg(REG_EDGE_CLASS, CFG_DATA_W'(EDGE_DL));
		write_reg(REG_BLOCK_SIZE, 8'd0);
		send_pattern({8'd50, 8'd50, 8'd0, 8'd50, 8'd10, 8'd50, 8'd0, 8'd50, 8'd50});
		drain();
		// band wraps from position 31 to band 0
		write_reg(REG_SAO_TYPE, CFG_DATA_W'(SAO_BAND));
		write_reg(REG_BAND_POSITION, 8'd31);
		write_reg(REG_OFFSET_SECOND, 8'h64);
		send_pattern({8'd0, 8'd255, 8'd7, 8'd128, 8'd5, 8'd64, 8'd255, 8'd0, 8'd3});
		drain();

		// size above the maximum; three full rows fill every line store column
		set_idling(3);
		randomize_config();
		write_reg(REG_BLOCK_SIZE, 8'hFF);
		repeat (200) send_random_item(0);
		drain();
		write_reg(REG_BLOCK_SIZE, 8'd2);
		send_block(0);
		drain();

		// block size shrinks mid-block
		set_idling(2);
		write_reg(REG_BLOCK_SIZE, 8'd8);
		repeat (52) send_random_item(0);
		drain();
		write_reg(REG_BLOCK_SIZE, 8'd2);
		send_block(0);
		drain();

		// block size grows mid-block
		set_idling(1);
		flat_base = 8'd100;
		write_reg(REG_SAO_TYPE, CFG_DATA_W'(SAO_EDGE));
		write_reg(REG_BLOCK_SIZE, 8'd2);
		repeat (6) send_random_item(1);
		drain();
		write_reg(REG_BLOCK_SIZE, 8'd6);
		send_block(1);

		rand_start = items_sent;
		while (items_sent - rand_start < RAND_ITEMS) begin
			drain();
			set_idling((items_sent - rand_start) / 200);
			randomize_config();
			repeat ($urandom_range(1, 3)) begin
				flat_base = SMP_W'($urandom_range(0, MAX_PIX - 2));
				send_block($urandom_range(0, 2));
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("PASS sample_adaptive_offset_filter_unit");
		else
			$display("FAIL sample_adaptive_offset_filter_unit");
		$finish;
	end

endmodule
